FILE: hdl/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
package mhpq_pkg;

  // Width of the entry count reported with every result
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_PEEK    = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SU_CMP,
    S_EX_LOAD,
    S_SD_CMP,
    S_PK_LOAD,
    S_RESP
  } state_e;

  // One heap entry as stored in memory
  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] uid;
    logic        kind;
  } entry_t;

  // Request payload as taken from the input channel
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] priority_req;
    logic [15:0] user_id;
    logic        access_kind;
  } req_t;

  // Result payload handed to the output register
  typedef struct packed {
    status_e             status;
    entry_t              ent;
    logic [CountW-1:0]   count;
  } rsp_t;

endpackage

FILE: hdl/mhpq_if.sv
// Valid/ready channel interfaces for requests and results.
interface mhpq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] priority_req;
  logic [15:0] user_id;
  logic        access_kind;

  modport source (output valid, opcode, priority_req, user_id, access_kind, input ready);
  modport sink (input valid, opcode, priority_req, user_id, access_kind, output ready);
endinterface

interface mhpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_priority;
  logic [15:0] out_user_id;
  logic        out_access_kind;
  logic [6:0]  entry_count;

  modport source (output valid, status, out_priority, out_user_id, out_access_kind,
                  entry_count, input ready);
  modport sink (input valid, status, out_priority, out_user_id, out_access_kind,
                entry_count, output ready);
endinterface

FILE: hdl/mhpq_mem.sv
// Heap storage: one write port, two read ports with registered read data.
module mhpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  mhpq_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output mhpq_pkg::entry_t  rdata_a_o,
  output mhpq_pkg::entry_t  rdata_b_o
);

  mhpq_pkg::entry_t mem_q [DEPTH];
  mhpq_pkg::entry_t rdata_a_q;
  mhpq_pkg::entry_t rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, registered read data
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/mhpq_ctrl.sv
// Heap sequencer: holds the entry count and walks sift-up / sift-down over the memory.
module mhpq_ctrl #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned CW       = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  mhpq_pkg::req_t    req_data_i,
  // memory side
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output mhpq_pkg::entry_t  mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_a_o,
  output logic [AW-1:0]     mem_raddr_b_o,
  input  mhpq_pkg::entry_t  mem_rdata_a_i,
  input  mhpq_pkg::entry_t  mem_rdata_b_i,
  // result side
  output logic              rsp_valid_o,
  output mhpq_pkg::rsp_t    rsp_data_o,
  input  logic              rsp_free_i
);

  // child indices can reach 2*CAPACITY
  localparam int unsigned XW      = CW + 1;
  localparam int unsigned OutCntW = mhpq_pkg::CountW;

  mhpq_pkg::state_e  state_q, state_d;
  mhpq_pkg::opcode_e op_q, op_d;
  mhpq_pkg::status_e stat_q, stat_d;
  mhpq_pkg::entry_t  ent_q, ent_d;   // entry being sifted (the hole's content)
  mhpq_pkg::entry_t  ret_q, ret_d;   // entry returned in the result
  logic [AW-1:0]     pos_q, pos_d;   // current hole position
  logic [CW-1:0]     cnt_q, cnt_d;   // entries held

  // sift-down helpers
  logic [XW-1:0]     lc_idx, rc_idx, c_idx, gl_idx, gr_idx;
  logic              pick_r, move_dn;
  mhpq_pkg::entry_t  cand;
  logic [AW-1:0]     par_pos;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] i);
    logic [AW-1:0] dec;
    dec = i - AW'(1);
    return (i == '0) ? '0 : (dec >> 1);
  endfunction

  // Address of a child if it exists, else entry zero (data then unused)
  function automatic logic [AW-1:0] child_addr(input logic [XW-1:0] idx,
                                               input logic [CW-1:0] cnt);
    return (idx < XW'(cnt)) ? idx[AW-1:0] : '0;
  endfunction

  // Child selection for sift-down; ties go to the left child
  always_comb begin
    lc_idx  = XW'({pos_q, 1'b1});
    rc_idx  = lc_idx + XW'(1);
    pick_r  = (rc_idx < XW'(cnt_q)) && (mem_rdata_b_i.prio > mem_rdata_a_i.prio);
    cand    = pick_r ? mem_rdata_b_i : mem_rdata_a_i;
    c_idx   = pick_r ? rc_idx : lc_idx;
    move_dn = (lc_idx < XW'(cnt_q)) && (cand.prio > ent_q.prio);
    gl_idx  = {c_idx[XW-2:0], 1'b1};
    gr_idx  = gl_idx + XW'(1);
    par_pos = parent_of(pos_q);
  end

  // State and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    stat_q <= stat_d;
    ent_q  <= ent_d;
    ret_q  <= ret_d;
    pos_q  <= pos_d;
  end

  // Next state, memory access and handshakes
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    stat_d        = stat_q;
    ent_d         = ent_q;
    ret_d         = ret_q;
    pos_d         = pos_q;
    cnt_d         = cnt_q;
    req_ready_o   = 1'b0;
    rsp_valid_o   = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = ent_q;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;

    case (state_q)
      mhpq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d       = mhpq_pkg::opcode_e'(req_data_i.opcode);
          ent_d.prio = req_data_i.priority_req;
          ent_d.uid  = req_data_i.user_id;
          ent_d.kind = req_data_i.access_kind;
          state_d    = mhpq_pkg::S_START;
        end
      end

      mhpq_pkg::S_START: begin
        stat_d  = mhpq_pkg::STAT_OK;
        ret_d   = '0;
        state_d = mhpq_pkg::S_RESP;
        case (op_q)
          mhpq_pkg::OP_INSERT: begin
            if (cnt_q == CW'(CAPACITY)) begin
              stat_d = mhpq_pkg::STAT_FULL;
            end else begin
              // hole at the new tail, fetch its parent
              pos_d         = cnt_q[AW-1:0];
              cnt_d         = cnt_q + CW'(1);
              mem_raddr_a_o = parent_of(cnt_q[AW-1:0]);
              state_d       = mhpq_pkg::S_SU_CMP;
            end
          end
          mhpq_pkg::OP_EXTRACT: begin
            if (cnt_q == '0) begin
              stat_d = mhpq_pkg::STAT_EMPTY;
            end else begin
              // fetch root and tail together
              mem_raddr_a_o = '0;
              mem_raddr_b_o = AW'(cnt_q - CW'(1));
              cnt_d         = cnt_q - CW'(1);
              state_d       = mhpq_pkg::S_EX_LOAD;
            end
          end
          mhpq_pkg::OP_PEEK: begin
            if (cnt_q == '0) begin
              stat_d = mhpq_pkg::STAT_EMPTY;
            end else begin
              mem_raddr_a_o = '0;
              state_d       = mhpq_pkg::S_PK_LOAD;
            end
          end
          default: begin
            state_d = mhpq_pkg::S_RESP;
          end
        endcase
      end

      // One level per cycle: parent data arrives, grandparent read goes out
      mhpq_pkg::S_SU_CMP: begin
        mem_we_o = 1'b1;
        if (pos_q != '0 && ent_q.prio > mem_rdata_a_i.prio) begin
          mem_wdata_o   = mem_rdata_a_i;
          pos_d         = par_pos;
          mem_raddr_a_o = parent_of(par_pos);
        end else begin
          state_d = mhpq_pkg::S_RESP;
        end
      end

      mhpq_pkg::S_EX_LOAD: begin
        ret_d         = mem_rdata_a_i;
        ent_d         = mem_rdata_b_i;
        pos_d         = '0;
        mem_raddr_a_o = child_addr(XW'(1), cnt_q);
        mem_raddr_b_o = child_addr(XW'(2), cnt_q);
        state_d       = mhpq_pkg::S_SD_CMP;
      end

      // One level per cycle: children arrive, the larger one moves up
      mhpq_pkg::S_SD_CMP: begin
        mem_we_o = 1'b1;
        if (move_dn) begin
          mem_wdata_o   = cand;
          pos_d         = c_idx[AW-1:0];
          mem_raddr_a_o = child_addr(gl_idx, cnt_q);
          mem_raddr_b_o = child_addr(gr_idx, cnt_q);
        end else begin
          state_d = mhpq_pkg::S_RESP;
        end
      end

      mhpq_pkg::S_PK_LOAD: begin
        ret_d   = mem_rdata_a_i;
        state_d = mhpq_pkg::S_RESP;
      end

      mhpq_pkg::S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_free_i) begin
          state_d = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_data_o.status = stat_q;
  assign rsp_data_o.ent    = ret_q;
  assign rsp_data_o.count  = OutCntW'(cnt_q);

endmodule

FILE: hdl/mhpq_out.sv
// Output register that decouples result transfers from the sequencer.
module mhpq_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ld_valid_i,
  input  mhpq_pkg::rsp_t  ld_data_i,
  output logic            free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output mhpq_pkg::rsp_t  data_o
);

  logic           valid_q, valid_d;
  mhpq_pkg::rsp_t data_q;
  logic           load;

  // Free when empty or the held result transfers this cycle
  assign free_o = !valid_q || ready_i;
  assign load   = ld_valid_i && free_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= ld_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hdl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue of access requests.
// Binary max-heap of CAPACITY requests (priority, user id, read/write kind) held in a
// single memory with one write and two read ports and a registered read. Insert places
// the request at the tail and sifts it up; extract returns the root, moves the tail to
// the root and sifts it down (on equal priorities the left child wins); peek returns the
// root. Each request yields one result carrying a status, the returned entry (zero when
// none) and the entry count after the operation (modulo 128). A request holds the block
// until its result enters the output register; on insert and extract the entry moves at
// most log2 of CAPACITY levels, one level per cycle, compared against the registered
// memory read data. Results wait in the output register, so a new request is taken
// while the previous result is still pending. No clearing pass follows reset; only
// entries below the count are used.
module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_req_if.sink    req_i,
  mhpq_rsp_if.source  rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  mhpq_pkg::req_t   req_data;
  mhpq_pkg::rsp_t   ld_data;
  mhpq_pkg::rsp_t   out_data;
  logic             ld_valid;
  logic             out_free;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr_a;
  logic [AW-1:0]    mem_raddr_b;
  mhpq_pkg::entry_t mem_wdata;
  mhpq_pkg::entry_t mem_rdata_a;
  mhpq_pkg::entry_t mem_rdata_b;

  // Request payload
  assign req_data.opcode       = req_i.opcode;
  assign req_data.priority_req = req_i.priority_req;
  assign req_data.user_id      = req_i.user_id;
  assign req_data.access_kind  = req_i.access_kind;

  mhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_ready_o   (req_i.ready),
    .req_data_i    (req_data),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b),
    .rsp_valid_o   (ld_valid),
    .rsp_data_o    (ld_data),
    .rsp_free_i    (out_free)
  );

  mhpq_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  mhpq_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_valid_i (ld_valid),
    .ld_data_i  (ld_data),
    .free_o     (out_free),
    .valid_o    (rsp_o.valid),
    .ready_i    (rsp_o.ready),
    .data_o     (out_data)
  );

  // Result payload
  assign rsp_o.status          = out_data.status;
  assign rsp_o.out_priority    = out_data.ent.prio;
  assign rsp_o.out_user_id     = out_data.ent.uid;
  assign rsp_o.out_access_kind = out_data.ent.kind;
  assign rsp_o.entry_count     = out_data.count;

endmodule
